@@ hw/rtl/u8dec_pkg.sv @@
// ----------------------------------------------------------------------------
// u8dec_pkg
// Shared types and constants for the byte-serial UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8dec_pkg;

  localparam int unsigned CpWidth   = 21;
  localparam int unsigned UsedWidth = 3;

  localparam logic [CpWidth-1:0] ReplacementCp = 21'h00FFFD;

  // result status codes
  typedef enum logic [1:0] {
    StatusValid     = 2'd0,
    StatusInvalid   = 2'd1,
    StatusTruncated = 2'd2
  } status_e;

  // decoder state carried between bytes
  typedef struct packed {
    logic [CpWidth-1:0] partial;
    logic [1:0]         pending;
    logic [1:0]         seen;
  } dec_state_t;

  // one result item
  typedef struct packed {
    logic [CpWidth-1:0]   code_point;
    logic [UsedWidth-1:0] bytes_used;
    status_e              status;
  } dec_result_t;

  // payload mask of a lead byte, by sequence length minus one
  function automatic logic [7:0] lead_mask(input logic [1:0] len_m1);
    logic [7:0] mask;
    case (len_m1)
      2'd0:    mask = 8'h7F;
      2'd1:    mask = 8'h1F;
      2'd2:    mask = 8'h0F;
      default: mask = 8'h07;
    endcase
    return mask;
  endfunction

endpackage

@@ hw/rtl/u8dec_step.sv @@
// ----------------------------------------------------------------------------
// u8dec_step
// Next-state and result logic for one byte or end-of-stream mark.
// ----------------------------------------------------------------------------
module u8dec_step (
  input  u8dec_pkg::dec_state_t  state_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   stream_end_i,
  output u8dec_pkg::dec_state_t  state_o,
  output logic                   emit_o,
  output u8dec_pkg::dec_result_t result_o
);
  import u8dec_pkg::*;

  logic                is_cont;
  logic                is_ascii;
  logic [1:0]          len_m1;
  logic [CpWidth-1:0]  shifted;
  logic [1:0]          pending_dec;
  dec_state_t          idle_state;

  // classify the byte
  always_comb begin
    is_ascii = ~data_byte_i[7];
    is_cont  = data_byte_i[7] & ~data_byte_i[6];
    if (~data_byte_i[5]) begin
      len_m1 = 2'd1;
    end else if (~data_byte_i[4]) begin
      len_m1 = 2'd2;
    end else begin
      len_m1 = 2'd3;
    end
  end

  assign shifted     = {state_i.partial[CpWidth-7:0], data_byte_i[5:0]};
  assign pending_dec = state_i.pending - 2'd1;
  assign idle_state  = '{partial: '0, pending: 2'd0, seen: 2'd0};

  // sequence tracking
  always_comb begin
    state_o  = state_i;
    emit_o   = 1'b0;
    result_o = '{code_point: ReplacementCp, bytes_used: 3'd1, status: StatusInvalid};
    if (stream_end_i) begin
      // end of stream cuts an open sequence short
      if (state_i.pending != 2'd0) begin
        emit_o   = 1'b1;
        result_o = '{code_point: ReplacementCp,
                     bytes_used: {1'b0, state_i.seen},
                     status:     StatusTruncated};
        state_o  = idle_state;
      end
    end else if (state_i.pending == 2'd0) begin
      if (is_cont) begin
        // stray continuation byte
        emit_o = 1'b1;
      end else if (is_ascii) begin
        emit_o   = 1'b1;
        result_o = '{code_point: {{(CpWidth-7){1'b0}}, data_byte_i[6:0]},
                     bytes_used: 3'd1,
                     status:     StatusValid};
      end else begin
        // multi-byte lead opens a sequence
        state_o.partial = {{(CpWidth-8){1'b0}}, data_byte_i & lead_mask(len_m1)};
        state_o.pending = len_m1;
        state_o.seen    = 2'd1;
      end
    end else if (!is_cont) begin
      // broken sequence, offending byte dropped
      emit_o   = 1'b1;
      result_o = '{code_point: ReplacementCp,
                   bytes_used: {1'b0, state_i.seen},
                   status:     StatusInvalid};
      state_o  = idle_state;
    end else if (pending_dec == 2'd0) begin
      // last continuation completes the code point
      emit_o   = 1'b1;
      result_o = '{code_point: shifted,
                   bytes_used: {1'b0, state_i.seen} + 3'd1,
                   status:     StatusValid};
      state_o  = idle_state;
    end else begin
      state_o.partial = shifted;
      state_o.pending = pending_dec;
      state_o.seen    = state_i.seen + 2'd1;
    end
  end

endmodule

@@ hw/rtl/utf8_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Byte-serial UTF-8 decoder with input register and result register.
// ----------------------------------------------------------------------------
// A result passes through the input register, then the result register.
// Throughput: one byte per cycle while the receiver does not stall, set by
// the combinational decode step between the two registers.
// Reset: asynchronous, clears both stages and returns the decoder to idle.
module utf8_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        stream_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [20:0] code_point_o,
  output logic [2:0]  bytes_used_o,
  output logic [1:0]  status_o
);
  import u8dec_pkg::*;

  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        end_q;
  logic        out_valid_q;
  logic        advance;
  logic        load;
  logic        emit;
  dec_state_t  state_q, state_d;
  dec_result_t result, result_q;

  // handshake control
  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~advance;
  assign load       = in_valid_i & ~in_stall_o;

  // decode step
  u8dec_step u_step (
    .state_i      (state_q),
    .data_byte_i  (byte_q),
    .stream_end_i (end_q),
    .state_o      (state_d),
    .emit_o       (emit),
    .result_o     (result)
  );

  // control and decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{partial: '0, pending: 2'd0, seen: 2'd0};
    end else begin
      if (load) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= emit;
        state_q     <= state_d;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= data_byte_i;
      end_q  <= stream_end_i;
    end
    if (advance && emit) begin
      result_q <= result;
    end
  end

  // result transfer
  assign out_valid_o  = out_valid_q;
  assign code_point_o = result_q.code_point;
  assign bytes_used_o = result_q.bytes_used;
  assign status_o     = result_q.status;

endmodule

@@ tb/utf8_stream_decoder_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_tb
// Self-checking bench for the byte-serial UTF-8 decoder. A queue of bytes and
// end marks feeds a clocked driver with random gaps, a clocked monitor decodes
// every accepted transfer in its own model and checks each result in order,
// and the receive side stalls at random. A watchdog ends a stuck run.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_tb;
  import u8dec_pkg::*;

  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned ReportMax   = 10;
  localparam int unsigned RandomItems = 450;
  localparam int unsigned TailCycles  = 8;
  localparam int unsigned MaxWait     = 8;

  // one pending transfer, or a pause until all results are back
  typedef struct packed {
    logic       drain;
    logic       eos;
    logic [7:0] data;
  } byte_item_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte  = 8'h00;
  logic        stream_end = 1'b0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [20:0] code_point;
  logic [2:0]  bytes_used;
  logic [1:0]  status;

  byte_item_t  byte_q[$];
  dec_result_t cp_expect_q[$];

  // decoder model state
  logic [CpWidth-1:0] cp_partial = '0;
  logic [1:0]         cp_pending = 2'd0;
  logic [1:0]         cp_seen    = 2'd0;

  logic        in_xfer     = 1'b0;
  logic        out_xfer    = 1'b0;
  logic        tx_calm     = 1'b0;
  logic        rx_calm     = 1'b0;
  int unsigned tx_gap      = 0;
  int unsigned rx_hold     = 0;
  int unsigned idle_cycles = 0;
  int unsigned fail_count  = 0;

  utf8_stream_decoder dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .data_byte_i  (data_byte),
    .stream_end_i (stream_end),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .code_point_o (code_point),
    .bytes_used_o (bytes_used),
    .status_o     (status)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // sequence length from the lead byte, 0 for a continuation byte
  function automatic int unsigned seq_length(input logic [7:0] b);
    if (!b[7]) return 1;
    if (!b[6]) return 0;
    if (!b[5]) return 2;
    if (!b[4]) return 3;
    return 4;
  endfunction

  // random lead byte of the given length, 0xf8-0xff included for length 4
  function automatic logic [7:0] lead_byte(input int unsigned len);
    logic [7:0] r;
    r = 8'($urandom_range(0, 255));
    case (len)
      1:       return {1'b0, r[6:0]};
      2:       return {3'b110, r[4:0]};
      3:       return {4'b1110, r[3:0]};
      default: return {4'b1111, r[3:0]};
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    logic [7:0] r;
    r = 8'($urandom_range(0, 255));
    return {2'b10, r[5:0]};
  endfunction

  // any byte that is not a continuation byte
  function automatic logic [7:0] non_cont_byte();
    logic [7:0] r;
    r = 8'($urandom_range(0, 255));
    if (r[7:6] == 2'b10) r[6] = 1'b1;
    return r;
  endfunction

  task automatic add_byte(input logic [7:0] b);
    byte_q.push_back('{drain: 1'b0, eos: 1'b0, data: b});
  endtask

  task automatic add_end();
    byte_q.push_back('{drain: 1'b0, eos: 1'b1, data: 8'($urandom_range(0, 255))});
  endtask

  task automatic add_drain();
    byte_q.push_back('{drain: 1'b1, eos: 1'b0, data: 8'h00});
  endtask

  task automatic push_result(input logic [CpWidth-1:0] cp, input logic [UsedWidth-1:0] used,
                             input status_e st);
    dec_result_t r;
    r.code_point = cp;
    r.bytes_used = used;
    r.status     = st;
    cp_expect_q.push_back(r);
  endtask

  task automatic clear_sequence();
    cp_partial = '0;
    cp_pending = 2'd0;
    cp_seen    = 2'd0;
  endtask

  // model of one accepted transfer
  task automatic decode_step(input logic [7:0] b, input logic eos);
    int unsigned len;
    logic [7:0]  payload;
    len = seq_length(b);
    if (eos) begin
      // end of stream only matters mid-sequence
      if (cp_pending != 2'd0) begin
        push_result(ReplacementCp, {1'b0, cp_seen}, StatusTruncated);
        clear_sequence();
      end
    end else if (cp_pending == 2'd0) begin
      if (len == 0) begin
        push_result(ReplacementCp, 3'd1, StatusInvalid);
      end else if (len == 1) begin
        push_result({14'd0, b[6:0]}, 3'd1, StatusValid);
      end else begin
        case (len)
          2:       payload = b & 8'h1F;
          3:       payload = b & 8'h0F;
          default: payload = b & 8'h07;
        endcase
        cp_partial = {13'd0, payload};
        cp_seen    = 2'd1;
        cp_pending = 2'(len - 1);
      end
    end else if (len != 0) begin
      // offending byte is dropped, not taken as a new lead
      push_result(ReplacementCp, {1'b0, cp_seen}, StatusInvalid);
      clear_sequence();
    end else begin
      cp_partial = {cp_partial[CpWidth-7:0], b[5:0]};
      cp_pending = cp_pending - 2'd1;
      if (cp_pending == 2'd0) begin
        push_result(cp_partial, {1'b0, cp_seen} + 3'd1, StatusValid);
        clear_sequence();
      end else begin
        cp_seen = cp_seen + 2'd1;
      end
    end
  endtask

  // driver: one transfer per byte or end-mark entry, random gap after each
  always @(negedge clk) begin : drive_bytes
    byte_item_t item;
    if (rst_n && !(in_valid && !in_xfer)) begin
      if (tx_gap != 0) begin
        tx_gap = tx_gap - 1;
        in_valid <= 1'b0;
      end else if (byte_q.size() != 0 && byte_q[0].drain) begin
        in_valid <= 1'b0;
        if (cp_expect_q.size() == 0) void'(byte_q.pop_front());
      end else if (byte_q.size() != 0) begin
        item = byte_q.pop_front();
        data_byte  <= item.data;
        stream_end <= item.eos;
        in_valid   <= 1'b1;
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        tx_gap = tx_calm ? 0 : $urandom_range(0, MaxWait);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall after each result transfer
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_xfer) begin
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        rx_hold = rx_calm ? 0 : $urandom_range(0, MaxWait);
      end
      if (rx_hold != 0) begin
        rx_hold = rx_hold - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor: predict on input transfers, check on output transfers
  always @(posedge clk) begin : watch_results
    dec_result_t want;
    in_xfer  <= in_valid && !in_stall;
    out_xfer <= out_valid && !out_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) decode_step(data_byte, stream_end);
      if (out_valid && !out_stall) begin
        if (cp_expect_q.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= ReportMax)
            $display("mismatch: unexpected result cp=%h used=%0d status=%0d",
                     code_point, bytes_used, status);
        end else begin
          want = cp_expect_q.pop_front();
          if (code_point !== want.code_point || bytes_used !== want.bytes_used ||
              status !== want.status) begin
            fail_count = fail_count + 1;
            if (fail_count <= ReportMax)
              $display("mismatch: cp=%h/%h used=%0d/%0d status=%0d/%0d (expected/actual)",
                       want.code_point, code_point, want.bytes_used, bytes_used,
                       want.status, status);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin : run_stimulus
    int unsigned added;
    int unsigned kind;
    int unsigned len;
    int unsigned k;
    logic        drained;
    added   = 0;
    drained = 1'b0;

    // ascii extremes and stray continuation bytes
    add_byte(8'h00); add_byte(8'h7F); add_byte(8'h80); add_byte(8'hBF);
    // two, three and four byte sequences
    add_byte(8'hC2); add_byte(8'hA9);
    add_byte(8'hE2); add_byte(8'h82); add_byte(8'hAC);
    add_byte(8'hF0); add_byte(8'h9F); add_byte(8'h98); add_byte(8'h80);
    // top lead byte as a four byte lead, largest code point
    add_byte(8'hFF); add_byte(8'hBF); add_byte(8'hBF); add_byte(8'hBF);
    // end of stream mid-sequence, then while idle
    add_byte(8'hE2); add_byte(8'h82); add_end(); add_end();
    // ascii and lead bytes breaking a sequence
    add_byte(8'hC3); add_byte(8'h41);
    add_byte(8'hE0); add_byte(8'hC2);
    add_drain();

    // random part: mostly well-formed sequences
    while (added < RandomItems) begin
      if (!drained && added >= RandomItems / 2) begin
        add_drain();
        drained = 1'b1;
      end
      kind = $urandom_range(0, 99);
      len  = $urandom_range(1, 4);
      if (kind < 10) begin
        if ($urandom_range(0, 7) == 0) add_end();
        else add_byte(8'($urandom_range(0, 255)));
        added = added + 1;
      end else begin
        add_byte(lead_byte(len));
        added = added + 1;
        if (kind < 65) begin
          k = len - 1;
        end else begin
          k = (len > 1) ? $urandom_range(0, len - 2) : 0;
        end
        repeat (k) add_byte(cont_byte());
        added = added + k;
        if (kind >= 65 && kind < 80) begin
          add_end();
          added = added + 1;
        end else if (kind >= 80) begin
          add_byte(non_cont_byte());
          added = added + 1;
        end
      end
    end

    // reset
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // wait for all transfers and results, then a short tail
    @(posedge clk);
    while (byte_q.size() != 0 || in_valid || cp_expect_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && cp_expect_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
